// File: rtl/first_fit_hole_allocator_defines.svh
// Assertion macros for the port-level checker of the hole allocator.
// No dependencies; the including file supplies i_clk and i_rst_n.
`ifndef FIRST_FIT_HOLE_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HOLE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FFHA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ffha_pkg.sv
// Types and fixed constants of the first-fit hole allocator.
// Has no dependencies; ffha_ctrl, the top level and the checker import it.
`default_nettype none

package ffha_pkg;

    // Fixed field widths of the stream items.
    localparam int OPC_W      = 2;
    localparam int FIELD_W    = 16;
    localparam int ADDR_W     = 22;
    localparam int IDX_OUT_W  = 6;
    localparam int STAT_W     = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 32;

    typedef enum logic [OPC_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_ALLOC  = 2'd2
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_FIT     = 2'd1,
        ST_TABLE_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // One input item, unpacked from the slave stream.
    typedef struct packed {
        logic [OPC_W-1:0]   opcode;
        logic [FIELD_W-1:0] block_size;
        logic               is_hole;
        logic [FIELD_W-1:0] request_size;
    } t_in_item;

    // One result item, as handed to the output register.
    typedef struct packed {
        t_status              status;
        logic [ADDR_W-1:0]    start_address;
        logic [IDX_OUT_W-1:0] hole_index;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/ffha_table.sv
// Block table storage: a single-port-write, single-port-read synchronous RAM.
// Read data is registered: it appears in the cycle after the read address. No package needed.
`default_nettype none

module ffha_table #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 34
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/ffha_ctrl.sv
// Sequencer of the allocator: decodes items, appends entries and scans the
// table for the first fitting hole. Depends on ffha_pkg.
`default_nettype none

module ffha_ctrl #(
    parameter int MAX_BLOCKS = 64,
    parameter int SIZE_BITS  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Item in
    input  wire logic                          i_item_valid,
    output logic                               o_item_ready,
    input  wire ffha_pkg::t_in_item            i_item,
    // Result out
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output ffha_pkg::t_result                  o_res,
    // Table RAM
    output logic                               o_wr_en,
    output logic [$clog2(MAX_BLOCKS)-1:0]      o_wr_addr,
    output logic [2*SIZE_BITS+1:0]             o_wr_data,
    output logic                               o_rd_en,
    output logic [$clog2(MAX_BLOCKS)-1:0]      o_rd_addr,
    input  wire logic [2*SIZE_BITS+1:0]        i_rd_data
);

    import ffha_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int PRE_W = SIZE_BITS + CNT_W;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [SIZE_BITS-1:0] r_req, n_req;
    logic [PRE_W-1:0]     r_prefix, n_prefix;
    t_result              r_res, n_res;

    // Fields of the entry being scanned: {size, consumed, hole, full}.
    logic [SIZE_BITS-1:0] ent_size, ent_used, ent_left;
    logic                 ent_hole, ent_full, ent_fits;

    assign ent_size = i_rd_data[2*SIZE_BITS+1:SIZE_BITS+2];
    assign ent_used = i_rd_data[SIZE_BITS+1:2];
    assign ent_hole = i_rd_data[1];
    assign ent_full = i_rd_data[0];
    assign ent_left = (ent_size >= ent_used) ? (ent_size - ent_used) : '0;
    assign ent_fits = ent_hole && !ent_full && (ent_left >= r_req);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Scan context and pending result.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_req    <= n_req;
        r_prefix <= n_prefix;
        r_res    <= n_res;
    end

    // Next state, table accesses and result.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_req        = r_req;
        n_prefix     = r_prefix;
        n_res        = r_res;
        o_item_ready = 1'b0;
        o_res_valid  = 1'b0;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_idx;
        o_wr_data    = i_rd_data;
        o_rd_en      = 1'b0;
        o_rd_addr    = '0;

        unique case (r_state)
            S_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    n_res   = '{status: ST_OK, start_address: '0, hole_index: '0};
                    n_state = S_DONE;
                    unique case (t_opcode'(i_item.opcode))
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_APPEND: begin
                            if (r_count >= CNT_W'(MAX_BLOCKS)) begin
                                n_res.status = ST_TABLE_FULL;
                            end else begin
                                // New entry starts with nothing consumed, not full.
                                o_wr_en   = 1'b1;
                                o_wr_addr = r_count[IDX_W-1:0];
                                o_wr_data = {SIZE_BITS'(i_item.block_size), {SIZE_BITS{1'b0}},
                                             i_item.is_hole, 1'b0};
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        OP_ALLOC: begin
                            n_req    = SIZE_BITS'(i_item.request_size);
                            n_idx    = '0;
                            n_prefix = '0;
                            if (r_count == '0) begin
                                n_res.status = ST_NO_FIT;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                            // Unused opcode: no change, plain ok result.
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (ent_fits) begin
                    // Take the request from the front of this hole.
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_idx;
                    o_wr_data = {ent_size, SIZE_BITS'(ent_used + r_req), ent_hole,
                                 (ent_left == r_req)};
                    n_res.status        = ST_OK;
                    n_res.start_address = ADDR_W'(r_prefix + PRE_W'(ent_used));
                    n_res.hole_index    = IDX_OUT_W'(r_idx);
                    n_state             = S_DONE;
                end else begin
                    n_prefix = r_prefix + PRE_W'(ent_size);
                    if (CNT_W'(r_idx) + CNT_W'(1) == r_count) begin
                        n_res.status = ST_NO_FIT;
                        n_state      = S_DONE;
                    end else begin
                        n_idx     = r_idx + IDX_W'(1);
                        o_rd_en   = 1'b1;
                        o_rd_addr = r_idx + IDX_W'(1);
                    end
                end
            end

            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// File: rtl/first_fit_hole_allocator.sv
// First-fit hole allocator. Each item is taken alone: clear and append items
// go straight to their result; an allocate item first scans the table from
// the first entry to the hole that serves it, or to the last entry when none
// fits. The scan is bound by the table RAM's single read port, which it walks
// one entry per cycle. The result sits in an output register, so the next item
// is taken while a result still waits downstream. No clearing pass runs after
// reset.
// Depends on ffha_pkg, ffha_ctrl and ffha_table.
`default_nettype none

module first_fit_hole_allocator #(
    parameter int MAX_BLOCKS = 64,
    parameter int SIZE_BITS  = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // block_size[15:0], is_hole[16], request_size[32:17], zero [39:33]
    input  wire logic [ffha_pkg::S_TDATA_W-1:0]    s_tdata,
    // opcode[1:0]
    input  wire logic [ffha_pkg::OPC_W-1:0]        s_tuser,
    // Result items
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // start_address[21:0], hole_index[27:22], zero [31:28]
    output logic [ffha_pkg::M_TDATA_W-1:0]         m_tdata,
    // status[1:0]
    output logic [ffha_pkg::STAT_W-1:0]            m_tuser
);

    import ffha_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int ENT_W = 2 * SIZE_BITS + 2;

    t_in_item         in_item;
    t_result          res;
    logic             res_valid, res_ready;
    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [ENT_W-1:0] wr_data, rd_data;

    logic             r_m_valid;
    t_result          r_m_res;

    // Unpack the input item.
    assign in_item.opcode       = s_tuser;
    assign in_item.block_size   = s_tdata[FIELD_W-1:0];
    assign in_item.is_hole      = s_tdata[FIELD_W];
    assign in_item.request_size = s_tdata[2*FIELD_W:FIELD_W+1];

    ffha_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_tvalid),
        .o_item_ready (s_tready),
        .i_item       (in_item),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data)
    );

    ffha_table #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (ENT_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register: loads when empty or being emptied this cycle.
    assign res_ready = !r_m_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_m_res <= res;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {{(M_TDATA_W - ADDR_W - IDX_OUT_W){1'b0}},
                       r_m_res.hole_index, r_m_res.start_address};
    assign m_tuser  = r_m_res.status;

endmodule

`default_nettype wire

// File: rtl/ffha_checker.sv
// Port-level checks of the first-fit hole allocator, bound to its top level.
// Depends on first_fit_hole_allocator_defines.svh and ffha_pkg.
`default_nettype none

`include "first_fit_hole_allocator_defines.svh"

module ffha_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [ffha_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [ffha_pkg::STAT_W-1:0]    m_tuser
);

    import ffha_pkg::*;

    // A stalled result item must hold.
    `FFHA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")

    // Failed requests carry neither an address nor an index.
    `FFHA_ASSERT_NOW(a_fail_zero, m_tvalid && (m_tuser != ST_OK), m_tdata == '0, "non-ok result carries address or index")

    // The reserved status code never appears.
    `FFHA_ASSERT_NOW(a_status_code, m_tvalid, (m_tuser == ST_OK) || (m_tuser == ST_NO_FIT) || (m_tuser == ST_TABLE_FULL), "reserved status code on output")

    // Items are worked one at a time: an accepted item blocks the next cycle.
    `FFHA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input accepted while previous item in work")

endmodule

bind first_fit_hole_allocator ffha_checker u_ffha_checker (.*);

`default_nettype wire
